### rtl/bvwa_pkg.sv
`timescale 1ns / 1ps
// Package for the battery voltage window average block.
// Holds field widths, register indexes and the divider status type; no dependencies.
package bvwa_pkg;

    localparam int RAW_W          = 12;
    localparam int MV_W           = 15;
    localparam int MV_MAX         = 32767;
    localparam int GAIN_W         = 15;
    localparam int GAIN_FRAC      = 14;
    localparam int FILL_OUT_W     = 5;
    localparam int CFG_DATA_W     = 15;
    localparam int WINDOW_DEFAULT = 20;

    localparam int SUM_W_DEFAULT  = $clog2(WINDOW_DEFAULT * MV_MAX + 1);
    localparam int FILL_W_DEFAULT = $clog2(WINDOW_DEFAULT + 1);
    localparam int IDX_W_DEFAULT  = $clog2(WINDOW_DEFAULT);

    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd16384;

    typedef logic [0:0] cfg_index_t;

    localparam cfg_index_t CFG_DIVIDER_GAIN      = 1'b0;
    localparam cfg_index_t CFG_CALIBRATION_VALID = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/bvwa_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the reading input and the mean result.
// Depends on bvwa_pkg for the field widths.
interface bvwa_in_if;
    import bvwa_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] calibrated_mv;

    modport source (output valid, output calibrated_mv, input ready);
    modport sink (input valid, input calibrated_mv, output ready);
endinterface

interface bvwa_out_if;
    import bvwa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MV_W-1:0]       battery_mv;
    logic [FILL_OUT_W-1:0] window_fill;

    modport source (output valid, output battery_mv, output window_fill, input ready);
    modport sink (input valid, input battery_mv, input window_fill, output ready);
endinterface

### rtl/bvwa_ring.sv
`timescale 1ns / 1ps
// Sample ring memory: one write port and one registered read port.
// Depends on bvwa_pkg for default widths.
module bvwa_ring
    import bvwa_pkg::*;
#(
    parameter int DEPTH = WINDOW_DEFAULT,
    parameter int IDX_W = IDX_W_DEFAULT
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [MV_W-1:0]  wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [MV_W-1:0]  rdata
);

    logic [MV_W-1:0] mem [DEPTH];
    logic [MV_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bvwa_divider.sv
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
// Depends on bvwa_pkg for default widths and the status struct.
module bvwa_divider
    import bvwa_pkg::*;
#(
    parameter int NUM_W = SUM_W_DEFAULT,
    parameter int DEN_W = FILL_W_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUM_W-1:0]        dividend,
    input  logic [DEN_W-1:0]        divisor,
    output bvwa_pkg::div_stat_t     stat,
    output logic [NUM_W-1:0]        quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic             fits;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

### rtl/battery_voltage_window_average.sv
`timescale 1ns / 1ps
// Top level: sequencer, scaling multiplier, running sum and output register.
// Depends on bvwa_pkg, bvwa_if, bvwa_ring and bvwa_divider.
//
//   Channel     Dir  Handshake          Payload
//   sample_in   in   valid/ready        calibrated_mv[11:0]
//   result_out  out  valid/ready        battery_mv[14:0], window_fill[4:0]
//   cfg         in   cfg_we only        cfg_index, cfg_data[14:0]
//
// An averaged transaction steps the sequencer through S_MUL, S_SCALE, S_ACC, S_START, S_DIV
// and S_OUT, with its mean loaded as the divider finishes; the bit-serial divider sets most of it.
// A transaction taken while calibration_valid is 0 goes from S_IDLE straight to S_OUT.
// The input is ready only while the sequencer is idle; the output register lets the next
// transaction be taken while a result waits, and a stalled output holds the sequencer.
// Reset clears the control state, the fill count, the write index, the sum and the last mean.
module battery_voltage_window_average #(
    parameter int WINDOW = bvwa_pkg::WINDOW_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bvwa_in_if.sink                           sample_in,
    bvwa_out_if.source                        result_out,
    input  logic                              cfg_we,
    input  bvwa_pkg::cfg_index_t              cfg_index,
    input  logic [bvwa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import bvwa_pkg::*;

    localparam int SUM_W  = $clog2(WINDOW * MV_MAX + 1);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int PROD_W = RAW_W + 2 + GAIN_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_SCALE = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [GAIN_W-1:0]     gain_reg;
    logic                  cal_valid_reg;
    logic [RAW_W-1:0]      mv_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [MV_W-1:0]       scaled_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [IDX_W-1:0]      widx_reg;
    logic [MV_W-1:0]       mean_reg;
    logic                  out_valid_reg;
    logic [MV_W-1:0]       out_mv_reg;
    logic [FILL_OUT_W-1:0] out_fill_reg;

    logic [RAW_W+1:0]      mv_times3;
    logic                  full;
    logic                  accept;
    logic                  out_load;
    logic [MV_W-1:0]       old_sample;
    logic [31:0]           fill_ext;
    div_stat_t             div_stat;
    logic [SUM_W-1:0]      div_quotient;

    assign accept    = sample_in.valid && sample_in.ready;
    assign full      = fill_reg == FILL_W'(WINDOW);
    assign mv_times3 = {2'b00, mv_reg} + {1'b0, mv_reg, 1'b0};
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || result_out.ready);
    assign fill_ext  = 32'(fill_reg);

    assign sample_in.ready        = state_reg == S_IDLE;
    assign result_out.valid       = out_valid_reg;
    assign result_out.battery_mv  = out_mv_reg;
    assign result_out.window_fill = out_fill_reg;

    bvwa_ring #(
        .DEPTH (WINDOW),
        .IDX_W (IDX_W)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == S_SCALE),
        .waddr (widx_reg),
        .wdata (prod_reg[GAIN_FRAC +: MV_W]),
        .re    (state_reg == S_MUL),
        .raddr (widx_reg),
        .rdata (old_sample)
    );

    bvwa_divider #(
        .NUM_W (SUM_W),
        .DEN_W (FILL_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_START),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RESET;
            cal_valid_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIVIDER_GAIN:      gain_reg      <= cfg_data[GAIN_W-1:0];
                CFG_CALIBRATION_VALID: cal_valid_reg <= cfg_data[0];
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = cal_valid_reg ? S_MUL : S_OUT;
                end
            end
            S_MUL:   state_next = S_SCALE;
            S_SCALE: state_next = S_ACC;
            S_ACC:   state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            fill_reg      <= '0;
            widx_reg      <= '0;
            mean_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SCALE && full)
            begin
                sum_reg <= sum_reg - SUM_W'(old_sample);
            end
            if (state_reg == S_ACC)
            begin
                sum_reg <= sum_reg + SUM_W'(scaled_reg);
                if (!full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (widx_reg == IDX_W'(WINDOW - 1))
                begin
                    widx_reg <= '0;
                end
                else
                begin
                    widx_reg <= widx_reg + 1'b1;
                end
            end
            if (state_reg == S_DIV && div_stat.done)
            begin
                mean_reg <= div_quotient[MV_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The product is at most 29 bits, so the shifted value never exceeds the 15-bit ceiling.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mv_reg <= sample_in.calibrated_mv;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(mv_times3) * PROD_W'(gain_reg);
        end
        if (state_reg == S_SCALE)
        begin
            scaled_reg <= prod_reg[GAIN_FRAC +: MV_W];
        end
        if (out_load)
        begin
            out_mv_reg   <= mean_reg;
            out_fill_reg <= fill_ext[FILL_OUT_W-1:0];
        end
    end

    a_ready_only_idle : assert property (@(posedge clk) disable iff (!rst_n)
        sample_in.ready |-> !div_stat.busy)
        else $error("input ready while the divider is busy");

    a_accept_to_mul : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cal_valid_reg) |=> (state_reg == S_MUL))
        else $error("averaged transaction did not enter the multiply step");

    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW))
        else $error("fill count above the window size");

    a_index_bound : assert property (@(posedge clk) disable iff (!rst_n)
        widx_reg <= IDX_W'(WINDOW - 1))
        else $error("write index outside the ring");

    a_done_in_div : assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

endmodule
